// File: rtl/core/pixel_format_converter_macros.svh
// ----------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shared concurrent assertion forms on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define PIXEL_FORMAT_CONVERTER_MACROS_SVH

// check cons in the same cycle as ante
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pfc_pkg.sv
// ----------------------------------------------------------------------------
// Pixel format converter package
// Encodings, register indexes and lane control types.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

    localparam logic [1:0] ENC_U8  = 2'd0;
    localparam logic [1:0] ENC_U16 = 2'd1;
    localparam logic [1:0] ENC_F16 = 2'd2;
    localparam logic [1:0] ENC_F32 = 2'd3;

    localparam logic CFG_IN_FORMAT  = 1'b0;
    localparam logic CFG_OUT_FORMAT = 1'b1;

    localparam logic [31:0] ONE_U8  = 32'h0000_00FF;
    localparam logic [31:0] ONE_U16 = 32'h0000_FFFF;
    localparam logic [31:0] ONE_F16 = 32'h0000_3C00;
    localparam logic [31:0] ONE_F32 = 32'h3F80_0000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

`default_nettype wire

// File: rtl/core/pfc_lane.sv
// ----------------------------------------------------------------------------
// Pixel format converter lane
// Three-stage channel path: decode to binary32, clamp and scale, encode.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_lane
    import pfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [31:0] raw,
    input  wire logic [3:0]  in_fmt,
    input  wire logic [3:0]  out_fmt,
    input  wire stage_en_t   en,
    output logic      [31:0] result
);

    function automatic logic [31:0] unorm_to_float(input logic [15:0] x);
        logic [63:0] w;
        logic [4:0]  lz;
        logic [31:0] r;
        lz = 5'd0;
        w  = 64'd0;
        if (x == 16'd0) begin
            r = 32'd0;
        end else if (x == 16'hFFFF) begin
            r = ONE_F32;
        end else begin
            for (int i = 0; i < 16; i++) begin
                if (x[i]) begin
                    lz = 5'(15 - i);
                end
            end
            w = {4{x}} << lz;
            r = {1'b0, 8'(8'd126 - {3'd0, lz}), w[62:40]} + {31'd0, w[39]};
        end
        return r;
    endfunction

    function automatic logic [31:0] half_to_float(input logic [15:0] h);
        logic [9:0]  m;
        logic [3:0]  s;
        logic [31:0] r;
        s = 4'd0;
        m = h[9:0];
        if (h[14:10] == 5'd0) begin
            if (m == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                for (int i = 0; i < 10; i++) begin
                    if (m[i]) begin
                        s = 4'(10 - i);
                    end
                end
                m = 10'(m << s);
                r = {h[15], 8'(8'd113 - {4'd0, s}), m, 13'd0};
            end
        end else if (h[14:10] == 5'h1F) begin
            r = {h[15], 8'hFF, m, 13'd0};
        end else begin
            r = {h[15], 8'({3'd0, h[14:10]} + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [15:0] float_to_half(input logic [31:0] b);
        logic               sgn;
        logic [7:0]         ex;
        logic [22:0]        man;
        logic signed [9:0]  es;
        logic [14:0]        h;
        logic [4:0]         shift;
        logic [23:0]        m24;
        logic [23:0]        q;
        logic               guard;
        logic               sticky;
        logic [15:0]        r;
        sgn   = b[31];
        ex    = b[30:23];
        man   = b[22:0];
        es    = $signed({2'b00, ex}) - 10'sd112;
        h     = 15'd0;
        shift = 5'd0;
        m24   = {1'b1, man};
        q     = 24'd0;
        guard = 1'b0;
        sticky = 1'b0;
        if (ex == 8'hFF) begin
            if (man == 23'd0) begin
                r = {sgn, 15'h7C00};
            end else begin
                r = {sgn, 5'h1F, man[22:13] | {9'd0, man[22:13] == 10'd0}};
            end
        end else if (ex == 8'd0) begin
            r = {sgn, 15'd0};
        end else if (es >= 10'sd31) begin
            r = {sgn, 15'h7C00};
        end else if (es >= 10'sd1) begin
            h = {es[4:0], man[22:13]};
            if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && h[0])) begin
                h = h + 15'd1;
            end
            r = {sgn, h};
        end else if (es < -10'sd10) begin
            r = {sgn, 15'd0};
        end else begin
            shift  = 5'(10'sd14 - es);
            q      = m24 >> shift;
            guard  = m24[shift - 5'd1];
            sticky = (m24 & ((24'd1 << (shift - 5'd1)) - 24'd1)) != 24'd0;
            q      = q + {23'd0, guard & (sticky | q[0])};
            r      = {sgn, q[14:0]};
        end
        return r;
    endfunction

    logic [31:0] f1_reg;
    logic [31:0] f1_next;
    logic [31:0] f2_reg;
    logic [31:0] f2_next;
    logic [39:0] p_reg;
    logic [39:0] p_next;
    logic [7:0]  e_reg;
    logic [31:0] res_reg;
    logic [31:0] res_next;

    logic [1:0]  in_enc;
    logic [1:0]  out_enc;
    logic [39:0] m40;
    logic        nan1;

    logic [4:0]  d;
    logic [39:0] q;
    logic        guard;
    logic        sticky;
    logic [39:0] pr;
    logic [7:0]  sh;
    logic [39:0] r;
    logic [31:0] maxv;

    assign in_enc  = in_fmt[3:2];
    assign out_enc = out_fmt[3:2];

    always_comb
    begin
        case (in_enc)
            ENC_U8:  f1_next = unorm_to_float({raw[7:0], raw[7:0]});
            ENC_U16: f1_next = unorm_to_float(raw[15:0]);
            ENC_F16: f1_next = half_to_float(raw[15:0]);
            default: f1_next = raw;
        endcase
    end

    assign nan1 = (f1_reg[30:23] == 8'hFF) && (f1_reg[22:0] != 23'd0);

    always_comb
    begin
        f2_next = f1_reg;
        if (!out_enc[1]) begin
            if (f1_reg[31] || nan1 || f1_reg[30:0] == 31'd0) begin
                f2_next = 32'd0;
            end else if (f1_reg[30:0] > ONE_F32[30:0]) begin
                f2_next = ONE_F32;
            end
        end
        m40 = {16'd0, 1'b1, f2_next[22:0]};
        if (out_enc == ENC_U8) begin
            p_next = (m40 << 8) - m40;
        end else begin
            p_next = (m40 << 16) - m40;
        end
    end

    always_comb
    begin
        if (out_enc == ENC_U8) begin
            d    = p_reg[31] ? 5'd8 : 5'd7;
            maxv = 32'd255;
        end else begin
            d    = p_reg[39] ? 5'd16 : 5'd15;
            maxv = 32'd65535;
        end
        q      = p_reg >> d;
        guard  = p_reg[d - 5'd1];
        sticky = (p_reg & ((40'd1 << (d - 5'd1)) - 40'd1)) != 40'd0;
        pr     = q + {39'd0, guard & (sticky | q[0])};
        sh     = 8'(8'd150 - e_reg - {3'd0, d});
        r      = pr >> sh;
        case (out_enc)
            ENC_U8, ENC_U16:
            begin
                if (e_reg == 8'd0) begin
                    res_next = 32'd0;
                end else if (r >= {8'd0, maxv}) begin
                    res_next = maxv;
                end else begin
                    res_next = r[31:0];
                end
            end
            ENC_F16: res_next = {16'd0, float_to_half(f2_reg)};
            default: res_next = f2_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            f1_reg <= f1_next;
        end
        if (en.s2)
        begin
            f2_reg <= f2_next;
            p_reg  <= p_next;
            e_reg  <= f2_next[30:23];
        end
        if (en.s3)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// Pixel format converter
// Converts one pixel per beat between R..RGBA in 8U, 16U, 16F and 32F.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  s_*      in   tdata: src_ch0..src_ch3 (128 bits), tlast: last_pixel
//  m_*      out  tdata: dst_ch0..dst_ch3 (128 bits), tuser: channel_count,
//                tlast: last_out
//  cfg_*    in   cfg_index 0: in_format, 1: out_format
//
//  One beat per cycle unless m_tready stalls the pipeline; three lane stages plus merge.
//  Four lanes run the channel path side by side; merge zeroes absent channels.
//  Each stage advances when the next one is empty or advancing.
//  Reset clears format registers and stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_converter
    import pfc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [3:0]   cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // src_ch0, src_ch1, src_ch2, src_ch3
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata,   // dst_ch0, dst_ch1, dst_ch2, dst_ch3
    output logic      [2:0]   m_tuser,   // channel_count
    output logic              m_tlast
);

    logic [3:0]   in_format_reg;
    logic [3:0]   out_format_reg;
    logic [3:0]   valid_reg;
    logic [2:0]   last_reg;
    logic [127:0] data_reg;
    logic [127:0] data_next;
    logic [2:0]   count_reg;
    logic         last_out_reg;

    logic [3:0]   rdy;
    stage_en_t    en;
    logic [31:0]  one_val;
    logic [31:0]  lane_raw [4];
    logic [31:0]  lane_res [4];
    logic [1:0]   in_n;

    assign rdy[3] = !valid_reg[3] || m_tready;
    assign rdy[2] = !valid_reg[2] || rdy[3];
    assign rdy[1] = !valid_reg[1] || rdy[2];
    assign rdy[0] = !valid_reg[0] || rdy[1];
    assign en     = '{s1: rdy[0], s2: rdy[1], s3: rdy[2]};

    assign s_tready = rdy[0];
    assign in_n     = in_format_reg[1:0];

    always_comb
    begin
        case (in_format_reg[3:2])
            ENC_U8:  one_val = ONE_U8;
            ENC_U16: one_val = ONE_U16;
            ENC_F16: one_val = ONE_F16;
            default: one_val = ONE_F32;
        endcase
        lane_raw[0] = s_tdata[31:0];
        lane_raw[1] = (in_n == 2'd0) ? s_tdata[31:0] : s_tdata[63:32];
        if (in_n == 2'd0) begin
            lane_raw[2] = s_tdata[31:0];
        end else if (in_n == 2'd1) begin
            lane_raw[2] = 32'd0;
        end else begin
            lane_raw[2] = s_tdata[95:64];
        end
        lane_raw[3] = (in_n == 2'd3) ? s_tdata[127:96] : one_val;
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        pfc_lane u_lane (
            .clk     (clk),
            .raw     (lane_raw[k]),
            .in_fmt  (in_format_reg),
            .out_fmt (out_format_reg),
            .en      (en),
            .result  (lane_res[k])
        );
        assign data_next[32*k +: 32] =
            (2'(k) <= out_format_reg[1:0]) ? lane_res[k] : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_format_reg  <= 4'd0;
            out_format_reg <= 4'd0;
            valid_reg      <= 4'd0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_IN_FORMAT)
            begin
                in_format_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_OUT_FORMAT)
            begin
                out_format_reg <= cfg_data;
            end
            if (rdy[0]) valid_reg[0] <= s_tvalid;
            if (rdy[1]) valid_reg[1] <= valid_reg[0];
            if (rdy[2]) valid_reg[2] <= valid_reg[1];
            if (rdy[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) last_reg[0] <= s_tlast;
        if (rdy[1]) last_reg[1] <= last_reg[0];
        if (rdy[2]) last_reg[2] <= last_reg[1];
        if (rdy[3])
        begin
            data_reg     <= data_next;
            count_reg    <= {1'b0, out_format_reg[1:0]} + 3'd1;
            last_out_reg <= last_reg[2];
        end
    end

    assign m_tvalid = valid_reg[3];
    assign m_tdata  = data_reg;
    assign m_tuser  = count_reg;
    assign m_tlast  = last_out_reg;

`include "pixel_format_converter_macros.svh"

    `PFC_ASSERT_NOW(a_count_range, m_tvalid, m_tuser != 3'd0 && m_tuser <= 3'd4, "bad channel count")
    `PFC_ASSERT_NOW(a_absent_zero, m_tvalid && m_tuser == 3'd1, m_tdata[127:32] == 96'd0, "absent channel not zero")
    `PFC_ASSERT_NOW(a_take_when_empty, !m_tvalid && s_tvalid, s_tready, "input refused with output empty")
    `PFC_ASSERT_NOW(a_u8_range, m_tvalid && out_format_reg[3:2] == ENC_U8, m_tdata[31:8] == 24'd0, "8-bit result out of range")

endmodule

`default_nettype wire
